@@ hdl/bc1_pkg.sv @@
// ----------------------------------------------------------------------------
// bc1_pkg
// Shared types, constants and palette build for the BC1 variant block decoder.
// ----------------------------------------------------------------------------
package bc1_pkg;

  localparam int unsigned ROWS_PER_BLOCK = 4;
  localparam int unsigned TEXELS_PER_ROW = 4;
  localparam int unsigned ROW_W          = $clog2(ROWS_PER_BLOCK);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS_PER_BLOCK - 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef logic [31:0] rgba_t;
  typedef logic [TEXELS_PER_ROW-1:0][31:0] pal_t;

  typedef struct packed {
    pal_t        pal;
    logic [31:0] idx;
  } bc1_blk_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [2:0][7:0] split565(input logic [15:0] c);
    logic [2:0][7:0] ch;
    ch[0] = widen5(c[15:11]);
    ch[1] = widen6(c[10:5]);
    ch[2] = widen5(c[4:0]);
    return ch;
  endfunction

  function automatic pal_t build_pal(input logic [15:0] c0, input logic [15:0] c1);
    logic            four;
    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic [2:0][7:0] m2;
    logic [2:0][7:0] m3;
    logic [10:0]     s2;
    logic [10:0]     s3;
    logic [8:0]      sa;
    pal_t            p;
    four = (c0 > c1);
    e0   = split565(c0);
    e1   = split565(c1);
    for (int k = 0; k < 3; k++) begin
      s2 = 11'(e0[k]) * 11'd5 + 11'(e1[k]) * 11'd3;
      s3 = 11'(e0[k]) * 11'd3 + 11'(e1[k]) * 11'd5;
      sa = 9'(e0[k]) + 9'(e1[k]);
      if (four) begin
        m2[k] = s2[10:3];
        m3[k] = s3[10:3];
      end else begin
        m2[k] = sa[8:1];
        m3[k] = sa[8:1];
      end
    end
    p[0] = {e0[0], e0[1], e0[2], ALPHA_OPAQUE};
    p[1] = {e1[0], e1[1], e1[2], ALPHA_OPAQUE};
    p[2] = {m2[0], m2[1], m2[2], ALPHA_OPAQUE};
    p[3] = {m3[0], m3[1], m3[2], four ? ALPHA_OPAQUE : ALPHA_CLEAR};
    return p;
  endfunction

endpackage

@@ hdl/bc1_pal.sv @@
// ----------------------------------------------------------------------------
// bc1_pal
// Input stage: builds the four-entry palette and holds it with the indices.
// ----------------------------------------------------------------------------
module bc1_pal (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_color0,
  input  logic [15:0]       in_color1,
  input  logic [31:0]       in_row_indices,
  output logic              blk_valid,
  input  logic              blk_ready,
  output bc1_pkg::bc1_blk_t blk
);
  import bc1_pkg::*;

  logic     blk_valid_r;
  logic     blk_valid_nxt;
  bc1_blk_t blk_r;

  assign in_ready      = !blk_valid_r || blk_ready;
  assign blk_valid_nxt = (in_valid && in_ready) ? 1'b1 :
                         (blk_ready ? 1'b0 : blk_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      blk_r.pal <= build_pal(in_color0, in_color1);
      blk_r.idx <= in_row_indices;
    end
  end

  assign blk_valid = blk_valid_r;
  assign blk       = blk_r;

endmodule

@@ hdl/bc1_row.sv @@
// ----------------------------------------------------------------------------
// bc1_row
// Row sequencer: walks the four rows of a block and registers each row result.
// ----------------------------------------------------------------------------
module bc1_row (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      blk_valid,
  output logic                      blk_ready,
  input  bc1_pkg::bc1_blk_t         blk,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bc1_pkg::ROW_W-1:0] out_row,
  output logic [31:0]               out_texel0,
  output logic [31:0]               out_texel1,
  output logic [31:0]               out_texel2,
  output logic [31:0]               out_texel3,
  output logic                      out_last
);
  import bc1_pkg::*;

  logic                              load;
  logic [ROW_W-1:0]                  row_cnt_r;
  logic [ROW_W-1:0]                  row_cnt_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [ROW_W-1:0]                  out_row_r;
  logic                              out_last_r;
  logic [TEXELS_PER_ROW-1:0][31:0]   texel_r;
  logic [TEXELS_PER_ROW-1:0][31:0]   texel_nxt;
  logic [7:0]                        row_bits;

  assign load      = blk_valid && (!out_valid_r || out_ready);
  assign blk_ready = load && (row_cnt_r == ROW_LAST);

  assign row_cnt_nxt   = load ? row_cnt_r + ROW_W'(1) : row_cnt_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  assign row_bits = blk.idx[8*row_cnt_r +: 8];

  always_comb begin
    for (int x = 0; x < TEXELS_PER_ROW; x++) begin
      texel_nxt[x] = blk.pal[row_bits[2*x +: 2]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_cnt_r   <= row_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= row_cnt_r;
      out_last_r <= (row_cnt_r == ROW_LAST);
      texel_r    <= texel_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_last   = out_last_r;
  assign out_texel0 = texel_r[0];
  assign out_texel1 = texel_r[1];
  assign out_texel2 = texel_r[2];
  assign out_texel3 = texel_r[3];

`ifndef ASSERT_OFF
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_row_r == ROW_LAST)))
    else $error("last flag disagrees with row number");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && out_row_r != ROW_LAST) |=>
      (!out_valid_r || out_row_r == $past(out_row_r) + ROW_W'(1)))
    else $error("row results out of order");

  a_no_early_release: assert property (@(posedge clk) disable iff (!rst_n)
    (row_cnt_r != ROW_LAST) |-> !blk_ready)
    else $error("block released before its last row");
`endif

endmodule

@@ hdl/bc1_variant_block_decoder_core.sv @@
// ----------------------------------------------------------------------------
// bc1_variant_block_decoder_core
// Decodes one 4x4 BC1-style block into four rows of RGBA8 texels.
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one compressed block per transaction (two RGB565 endpoints and
//           four index bytes), valid/ready
//   out_* : one row per transaction, top row first, four RGBA8 texels each;
//           out_last marks the fourth row
//   pipeline: input stage registers the block, row sequencer each row
//   throughput: one row per cycle while out_ready is high; the row
//           sequencer is the limit, and the next block is taken while the
//           last row of the previous one waits in the output register
//   stall: with out_ready low the current row holds; the input stage keeps
//           one block and drops in_ready until its last row is loaded
//   reset: rst_n low, synchronous, empties both stages; no state survives
//           between blocks
// ----------------------------------------------------------------------------
module bc1_variant_block_decoder_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               in_color0,
  input  logic [15:0]               in_color1,
  input  logic [31:0]               in_row_indices,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bc1_pkg::ROW_W-1:0] out_row,
  output logic [31:0]               out_texel0,
  output logic [31:0]               out_texel1,
  output logic [31:0]               out_texel2,
  output logic [31:0]               out_texel3,
  output logic                      out_last
);
  import bc1_pkg::*;

  logic     blk_valid;
  logic     blk_ready;
  bc1_blk_t blk;

  bc1_pal u_pal (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_color0      (in_color0),
    .in_color1      (in_color1),
    .in_row_indices (in_row_indices),
    .blk_valid      (blk_valid),
    .blk_ready      (blk_ready),
    .blk            (blk)
  );

  bc1_row u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .blk_valid  (blk_valid),
    .blk_ready  (blk_ready),
    .blk        (blk),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_texel0 (out_texel0),
    .out_texel1 (out_texel1),
    .out_texel2 (out_texel2),
    .out_texel3 (out_texel3),
    .out_last   (out_last)
  );

endmodule
